/* src/mm_pkg.sv */
// Shared types, codes and helpers for the matrix multiply block.
// No dependencies; used by mm_mac and matrix_multiply.
package mm_pkg;

	localparam int MAX_DIM_DEF = 8;
	localparam int IDX_W       = 3;   // row / column field width
	localparam int CFG_W       = 4;   // dimension register width
	localparam int CFG_IDX_W   = 2;
	localparam int ELEM_W      = 16;  // Q8.8
	localparam int PROD_W      = 2 * ELEM_W;
	localparam int SUM_W       = 36;  // Q20.16, holds MAX_DIM products

	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	// request modes
	localparam logic [1:0] MODE_LOAD_A   = 2'd0;
	localparam logic [1:0] MODE_LOAD_B   = 2'd1;
	localparam logic [1:0] MODE_MULTIPLY = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

	typedef struct packed {
		logic [1:0]              mode;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        column;
		logic signed [ELEM_W-1:0] element;
	} request_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_row;
		logic [IDX_W-1:0]        out_column;
		logic signed [SUM_W-1:0] product;
		logic                    status;
		logic                    last;
	} result_t;

	// control that travels with each term of a dot product
	typedef struct packed {
		logic             first;  // first term: restart the sum
		logic             endk;   // final term: sum is complete
		logic             last;   // final element of the run
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
	} term_tag_t;

	// a zero register counts as 1, anything above max counts as max
	function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] max_dim);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (v > max_dim) begin
			r = max_dim;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* src/mm_mac.sv */
// Multiply-accumulate stage: registered 16x16 product, then 36-bit sum.
// Depends on mm_pkg.
module mm_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  mm_pkg::term_tag_t                  tag,
	input  logic signed [mm_pkg::ELEM_W-1:0]   a,
	input  logic signed [mm_pkg::ELEM_W-1:0]   b,
	output logic                               sum_valid,
	output mm_pkg::term_tag_t                  sum_tag,
	output logic signed [mm_pkg::SUM_W-1:0]    sum
);

	logic                                 valid_s2;
	mm_pkg::term_tag_t                    tag_s2;
	logic signed [mm_pkg::PROD_W-1:0]     prod_s2;
	logic signed [mm_pkg::SUM_W-1:0]      acc_q;
	logic signed [mm_pkg::SUM_W-1:0]      acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2  <= tag;
		prod_s2 <= a * b;
		if (valid_s2) begin
			acc_q <= acc_next;
		end
	end

	assign acc_next = (tag_s2.first ? '0 : acc_q) + mm_pkg::SUM_W'(prod_s2);

	assign sum_valid = valid_s2 & tag_s2.endk;
	assign sum_tag   = tag_s2;
	assign sum       = acc_next;

	// a continuing term follows straight on from the previous term
	a_term_contig: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !tag.first |-> $past(in_valid))
		else $error("mm_mac: continuing term without a predecessor");

	// the term after a completed sum starts a new one
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && $past(in_valid && tag.endk) |-> tag.first)
		else $error("mm_mac: sum not restarted after final term");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && tag.last |-> tag.endk)
		else $error("mm_mac: last mark on a term that does not end a sum");

endmodule

/* src/matrix_multiply.sv */
// Dense matrix multiply, top level: config registers, A/B element memories,
// read sequencer and output register. Depends on mm_pkg and mm_mac.
// A load is written at its accept edge; a multiply issues one memory read a cycle, set
// by the single read port of each memory; busy stays high until the final result strobes.
// Dimension mismatch: one error result strobes the cycle after accept.
// Loads: one per cycle while idle.
// Reset clears config to 8x8 and the control state; memory contents are undefined.
module matrix_multiply #(
	parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  mm_pkg::request_t               request,
	output logic                           done,
	output mm_pkg::result_t                result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]       cfg_data
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [mm_pkg::CFG_W-1:0] MAX_DIM_C = mm_pkg::CFG_W'(MAX_DIM);
	localparam logic [ADDR_W-1:0]        STRIDE    = ADDR_W'(MAX_DIM);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [mm_pkg::CFG_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [mm_pkg::CFG_W-1:0] ra_eff, ca_eff, rb_eff, cb_eff;
	logic [mm_pkg::IDX_W-1:0] ra_last, ca_last, cb_last;

	logic [1:0]               state_q;
	logic [mm_pkg::IDX_W-1:0] i_q, j_q, k_q;

	logic accept, in_range, we_a, we_b, dims_ok, issue;
	logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
	mm_pkg::term_tag_t issue_tag;

	logic signed [mm_pkg::ELEM_W-1:0] mem_a [DEPTH];
	logic signed [mm_pkg::ELEM_W-1:0] mem_b [DEPTH];
	logic signed [mm_pkg::ELEM_W-1:0] a_s1, b_s1;
	logic                             valid_s1;
	mm_pkg::term_tag_t                tag_s1;

	logic                             sum_valid;
	mm_pkg::term_tag_t                sum_tag;
	logic signed [mm_pkg::SUM_W-1:0]  sum;

	logic            done_q;
	mm_pkg::result_t result_q;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= mm_pkg::DIM_RESET;
			cols_a_q <= mm_pkg::DIM_RESET;
			rows_b_q <= mm_pkg::DIM_RESET;
			cols_b_q <= mm_pkg::DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mm_pkg::REG_ROWS_A: rows_a_q <= cfg_data;
				mm_pkg::REG_COLS_A: cols_a_q <= cfg_data;
				mm_pkg::REG_ROWS_B: rows_b_q <= cfg_data;
				mm_pkg::REG_COLS_B: cols_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ra_eff  = mm_pkg::eff_dim(rows_a_q, MAX_DIM_C);
	assign ca_eff  = mm_pkg::eff_dim(cols_a_q, MAX_DIM_C);
	assign rb_eff  = mm_pkg::eff_dim(rows_b_q, MAX_DIM_C);
	assign cb_eff  = mm_pkg::eff_dim(cols_b_q, MAX_DIM_C);
	assign ra_last = mm_pkg::IDX_W'(ra_eff - 1'b1);
	assign ca_last = mm_pkg::IDX_W'(ca_eff - 1'b1);
	assign cb_last = mm_pkg::IDX_W'(cb_eff - 1'b1);
	assign dims_ok = (rb_eff == ca_eff);

	// loads outside the store are dropped
	assign in_range = ({1'b0, request.row} < MAX_DIM_C) &&
	                  ({1'b0, request.column} < MAX_DIM_C);
	assign we_a     = accept && (request.mode == mm_pkg::MODE_LOAD_A) && in_range;
	assign we_b     = accept && (request.mode == mm_pkg::MODE_LOAD_B) && in_range;
	assign wr_addr  = ADDR_W'(request.row) * STRIDE + ADDR_W'(request.column);

	assign issue     = (state_q == ST_RUN);
	assign rd_addr_a = ADDR_W'(i_q) * STRIDE + ADDR_W'(k_q);
	assign rd_addr_b = ADDR_W'(k_q) * STRIDE + ADDR_W'(j_q);

	always_comb begin
		issue_tag.first = (k_q == '0);
		issue_tag.endk  = (k_q == ca_last);
		issue_tag.last  = (i_q == ra_last) && (j_q == cb_last) && (k_q == ca_last);
		issue_tag.i     = i_q;
		issue_tag.j     = j_q;
	end

	// sequencer: k innermost, then j, then i
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && request.mode == mm_pkg::MODE_MULTIPLY && dims_ok) begin
						state_q <= ST_RUN;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_RUN: begin
					if (k_q == ca_last) begin
						k_q <= '0;
						if (j_q == cb_last) begin
							j_q <= '0;
							if (i_q == ra_last) begin
								state_q <= ST_DRAIN;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (done_q && result_q.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// element memories; writes only while idle, so reads never overlap them
	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[wr_addr] <= request.element;
		end
		if (we_b) begin
			mem_b[wr_addr] <= request.element;
		end
		a_s1   <= mem_a[rd_addr_a];
		b_s1   <= mem_b[rd_addr_b];
		tag_s1 <= issue_tag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	mm_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.tag       (tag_s1),
		.a         (a_s1),
		.b         (b_s1),
		.sum_valid (sum_valid),
		.sum_tag   (sum_tag),
		.sum       (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sum_valid ||
			          (accept && request.mode == mm_pkg::MODE_MULTIPLY && !dims_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (sum_valid) begin
			result_q.out_row    <= sum_tag.i;
			result_q.out_column <= sum_tag.j;
			result_q.product    <= sum;
			result_q.status     <= 1'b0;
			result_q.last       <= sum_tag.last;
		end else begin
			// error result for incompatible dimensions
			result_q.out_row    <= '0;
			result_q.out_column <= '0;
			result_q.product    <= '0;
			result_q.status     <= 1'b1;
			result_q.last       <= 1'b1;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(we_a || we_b) |-> !busy)
		else $error("matrix_multiply: memory write while a multiply runs");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status |-> result.last && !$past(busy))
		else $error("matrix_multiply: malformed error result");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.last && !result.status |=> state_q == ST_IDLE)
		else $error("matrix_multiply: still busy after final result");

	a_ok_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.status |-> state_q == ST_RUN || state_q == ST_DRAIN)
		else $error("matrix_multiply: product result outside a run");

endmodule
